// ----- hw/rtl/oisc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oisc_pkg - shared definitions for the subnet classifier
// Command and status codes, default sizes and the cell control types.
// ----------------------------------------------------------------------------
package oisc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned DEST_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

    // Lookup token flags travelling along the chain
    typedef struct packed {
        logic act;
        logic found;
    } t_tok_flags;

endpackage

// ----- hw/rtl/oisc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oisc_cell - one rule slot of the classifier chain
// Holds one rule, shifts it to or from its neighbours on insert and delete,
// and tests the lookup token that passes through it once per cycle.
// ----------------------------------------------------------------------------
module oisc_cell #(
    parameter int unsigned IDX       = 0,
    parameter int unsigned CNT_W     = 5,
    parameter int unsigned IDX_W     = 4,
    parameter int unsigned DEST_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  oisc_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]       i_pos,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [31:0]            i_new_net,
    input  logic [31:0]            i_new_mask,
    input  logic [DEST_BITS-1:0]   i_new_dest,
    input  logic [31:0]            i_prev_net,
    input  logic [31:0]            i_prev_mask,
    input  logic [DEST_BITS-1:0]   i_prev_dest,
    input  logic [31:0]            i_next_net,
    input  logic [31:0]            i_next_mask,
    input  logic [DEST_BITS-1:0]   i_next_dest,
    output logic [31:0]            o_net,
    output logic [31:0]            o_mask,
    output logic [DEST_BITS-1:0]   o_dest,
    input  oisc_pkg::t_tok_flags   i_tok,
    input  logic [31:0]            i_tok_ip,
    input  logic [DEST_BITS-1:0]   i_tok_tag,
    input  logic [IDX_W-1:0]       i_tok_idx,
    output oisc_pkg::t_tok_flags   o_tok,
    output logic [31:0]            o_tok_ip,
    output logic [DEST_BITS-1:0]   o_tok_tag,
    output logic [IDX_W-1:0]       o_tok_idx
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    logic [31:0]          r_net,  n_net;
    logic [31:0]          r_mask, n_mask;
    logic [DEST_BITS-1:0] r_dest, n_dest;

    oisc_pkg::t_tok_flags r_tok, n_tok;
    logic [31:0]          r_tok_ip;
    logic [DEST_BITS-1:0] r_tok_tag, n_tok_tag;
    logic [IDX_W-1:0]     r_tok_idx, n_tok_idx;

    logic live;
    logic match;

    always_comb begin
        n_net  = r_net;
        n_mask = r_mask;
        n_dest = r_dest;
        if (i_ctl.ins && (MY_POS > i_pos)) begin
            n_net  = i_prev_net;
            n_mask = i_prev_mask;
            n_dest = i_prev_dest;
        end else if (i_ctl.ins && (MY_POS == i_pos)) begin
            n_net  = i_new_net;
            n_mask = i_new_mask;
            n_dest = i_new_dest;
        end else if (i_ctl.del && (MY_POS >= i_pos)) begin
            n_net  = i_next_net;
            n_mask = i_next_mask;
            n_dest = i_next_dest;
        end
    end

    // first live rule that matches claims the token
    assign live  = (MY_POS < i_count);
    assign match = i_tok.act && !i_tok.found && live
                   && ((i_tok_ip & r_mask) == r_net);

    always_comb begin
        n_tok     = i_tok;
        n_tok_tag = i_tok_tag;
        n_tok_idx = i_tok_idx;
        if (match) begin
            n_tok.found = 1'b1;
            n_tok_tag   = r_dest;
            n_tok_idx   = IDX_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_net     <= n_net;
        r_mask    <= n_mask;
        r_dest    <= n_dest;
        r_tok_ip  <= i_tok_ip;
        r_tok_tag <= n_tok_tag;
        r_tok_idx <= n_tok_idx;
    end

    assign o_net     = r_net;
    assign o_mask    = r_mask;
    assign o_dest    = r_dest;
    assign o_tok     = r_tok;
    assign o_tok_ip  = r_tok_ip;
    assign o_tok_tag = r_tok_tag;
    assign o_tok_idx = r_tok_idx;

endmodule

// ----- hw/rtl/ordered_ip_subnet_classifier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_ip_subnet_classifier_core - ordered first-match subnet classifier
// Table of network/mask/tag rules in a row of cells, searched in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_valid / o_stall, command fields on separate ports.
//   Output channel : o_valid / i_stall, one result transaction per command.
//   One command is in flight at a time; o_stall is high from acceptance
//   until its result has moved into the output register.
//   Lookup : the query token walks the chain one cell per cycle, then its
//            result passes through the pending stage into the output
//            register. The chain length sets how long a lookup takes.
//   Insert / delete / clear : the table is updated at acceptance, with all
//            cells shifting together on insert and delete; the result goes
//            to the pending stage and then to the output register.
//   A held result does not block the next command: the block takes it
//   while the receiver stalls, and parks its result in a pending stage.
//   Reset empties the table (rule count to zero) and drops any transaction
//   in flight; rule contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_ip_subnet_classifier_core #(
    parameter int unsigned TABLE_DEPTH = oisc_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned DEST_BITS   = oisc_pkg::DEST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_ip_addr,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_rule_network,
    input  logic [31:0] i_rule_mask,
    input  logic [15:0] i_rule_dest,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [15:0] o_dest_tag,
    output logic [3:0]  o_match_index,
    output logic [4:0]  o_entry_count,
    output logic [1:0]  o_status
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    // compare width wide enough for both the position port and the count
    localparam int unsigned PW    = (CNT_W > 5) ? CNT_W : 5;

    // control
    logic                 r_busy;
    logic [CNT_W-1:0]     r_count, n_count;

    // pending result stage
    logic                 r_pend_v;
    logic                 r_pend_hit;
    logic [DEST_BITS-1:0] r_pend_tag;
    logic [IDX_W-1:0]     r_pend_idx;
    logic [CNT_W-1:0]     r_pend_cnt;
    oisc_pkg::t_status    r_pend_st, n_st;

    logic accept;
    logic is_lookup;
    logic full;
    logic ins_ok;
    logic del_ok;
    logic out_load;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;

    oisc_pkg::t_cell_ctl  cell_ctl;
    logic [DEST_BITS-1:0] new_dest;

    // chain wiring
    logic [31:0]          net_w  [TABLE_DEPTH];
    logic [31:0]          mask_w [TABLE_DEPTH];
    logic [DEST_BITS-1:0] dest_w [TABLE_DEPTH];

    oisc_pkg::t_tok_flags tok_f   [TABLE_DEPTH+1];
    logic [31:0]          tok_ip  [TABLE_DEPTH+1];
    logic [DEST_BITS-1:0] tok_tag [TABLE_DEPTH+1];
    logic [IDX_W-1:0]     tok_idx [TABLE_DEPTH+1];

    assign accept    = i_valid && !r_busy;
    assign is_lookup = (oisc_pkg::t_cmd'(i_cmd) == oisc_pkg::CMD_LOOKUP);
    assign pos_ext   = PW'(i_position);
    assign cnt_ext   = PW'(r_count);
    assign full      = (r_count == CNT_W'(TABLE_DEPTH));
    // full check takes priority over the range check
    assign ins_ok    = !full && (pos_ext <= cnt_ext);
    assign del_ok    = (pos_ext < cnt_ext);
    assign new_dest  = DEST_BITS'(i_rule_dest);

    always_comb begin
        cell_ctl = '0;
        n_count  = r_count;
        n_st     = oisc_pkg::ST_OK;
        case (oisc_pkg::t_cmd'(i_cmd))
            oisc_pkg::CMD_LOOKUP: begin
                n_st = oisc_pkg::ST_OK;
            end
            oisc_pkg::CMD_INSERT: begin
                if (full) begin
                    n_st = oisc_pkg::ST_FULL;
                end else if (!ins_ok) begin
                    n_st = oisc_pkg::ST_RANGE;
                end else begin
                    cell_ctl.ins = accept;
                    n_count      = CNT_W'(r_count + 1'b1);
                end
            end
            oisc_pkg::CMD_DELETE: begin
                if (!del_ok) begin
                    n_st = oisc_pkg::ST_RANGE;
                end else begin
                    cell_ctl.del = accept;
                    n_count      = CNT_W'(r_count - 1'b1);
                end
            end
            oisc_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // query token entering the head of the chain
    assign tok_f[0].act   = accept && is_lookup;
    assign tok_f[0].found = 1'b0;
    assign tok_ip[0]      = i_ip_addr;
    assign tok_tag[0]     = '0;
    assign tok_idx[0]     = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [31:0]          prev_net, prev_mask, next_net, next_mask;
        logic [DEST_BITS-1:0] prev_dest, next_dest;

        if (g == 0) begin : g_head
            assign prev_net  = i_rule_network;
            assign prev_mask = i_rule_mask;
            assign prev_dest = new_dest;
        end else begin : g_mid
            assign prev_net  = net_w[g-1];
            assign prev_mask = mask_w[g-1];
            assign prev_dest = dest_w[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign next_net  = net_w[g];
            assign next_mask = mask_w[g];
            assign next_dest = dest_w[g];
        end else begin : g_body
            assign next_net  = net_w[g+1];
            assign next_mask = mask_w[g+1];
            assign next_dest = dest_w[g+1];
        end

        oisc_cell #(
            .IDX       (g),
            .CNT_W     (CNT_W),
            .IDX_W     (IDX_W),
            .DEST_BITS (DEST_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_pos       (CNT_W'(pos_ext)),
            .i_count     (r_count),
            .i_new_net   (i_rule_network),
            .i_new_mask  (i_rule_mask),
            .i_new_dest  (new_dest),
            .i_prev_net  (prev_net),
            .i_prev_mask (prev_mask),
            .i_prev_dest (prev_dest),
            .i_next_net  (next_net),
            .i_next_mask (next_mask),
            .i_next_dest (next_dest),
            .o_net       (net_w[g]),
            .o_mask      (mask_w[g]),
            .o_dest      (dest_w[g]),
            .i_tok       (tok_f[g]),
            .i_tok_ip    (tok_ip[g]),
            .i_tok_tag   (tok_tag[g]),
            .i_tok_idx   (tok_idx[g]),
            .o_tok       (tok_f[g+1]),
            .o_tok_ip    (tok_ip[g+1]),
            .o_tok_tag   (tok_tag[g+1]),
            .o_tok_idx   (tok_idx[g+1])
        );
    end

    // pending result moves on once the output register is free
    assign out_load = r_pend_v && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
            end else if (out_load) begin
                r_busy  <= 1'b0;
            end

            if (accept && !is_lookup) begin
                r_pend_v <= 1'b1;
            end else if (tok_f[TABLE_DEPTH].act) begin
                r_pend_v <= 1'b1;
            end else if (out_load) begin
                r_pend_v <= 1'b0;
            end

            if (out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end

        // result payload
        if (accept && !is_lookup) begin
            r_pend_hit <= 1'b0;
            r_pend_tag <= '0;
            r_pend_idx <= '0;
            r_pend_cnt <= n_count;
            r_pend_st  <= n_st;
        end else if (tok_f[TABLE_DEPTH].act) begin
            r_pend_hit <= tok_f[TABLE_DEPTH].found;
            r_pend_tag <= tok_tag[TABLE_DEPTH];
            r_pend_idx <= tok_idx[TABLE_DEPTH];
            r_pend_cnt <= r_count;
            r_pend_st  <= oisc_pkg::ST_OK;
        end

        if (out_load) begin
            o_hit         <= r_pend_hit;
            o_dest_tag    <= 16'(r_pend_tag);
            o_match_index <= 4'(r_pend_idx);
            o_entry_count <= 5'(r_pend_cnt);
            o_status      <= r_pend_st;
        end
    end

    assign o_stall = r_busy;

endmodule

// ----- dv/ordered_ip_subnet_classifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_ip_subnet_classifier_checker - result checker for the classifier
// Watches both channels, keeps its own copy of the rule table, predicts every
// result in order and compares it field by field.
// ----------------------------------------------------------------------------
module ordered_ip_subnet_classifier_checker
    import oisc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_cmd_valid,
    input  logic        i_cmd_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_ip_addr,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_rule_network,
    input  logic [31:0] i_rule_mask,
    input  logic [15:0] i_rule_dest,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_hit,
    input  logic [15:0] i_dest_tag,
    input  logic [3:0]  i_match_index,
    input  logic [4:0]  i_entry_count,
    input  logic [1:0]  i_status,
    // to the test top
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_results_seen,
    output int          o_lookup_hits,
    output int          o_full_refusals,
    output int          o_range_refusals
);

    localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic        hit;
        logic [15:0] tag;
        logic [3:0]  idx;
        logic [4:0]  count;
        t_status     status;
    } t_answer;

    logic [31:0] net_tbl  [DEPTH];
    logic [31:0] mask_tbl [DEPTH];
    logic [15:0] tag_tbl  [DEPTH];
    int unsigned rules_held;

    t_answer answers_due[$];
    int      mismatches;
    int      results;
    int      hits;
    int      fulls;
    int      ranges;

    // Applies one command to the table copy and returns the answer it owes
    function automatic t_answer step_rule_table(t_cmd op, logic [31:0] ip, logic [4:0] pos,
                                                logic [31:0] net, logic [31:0] msk,
                                                logic [15:0] dst);
        t_answer a;
        int      i;
        logic    found;
        a     = '0;
        found = 1'b0;
        case (op)
            CMD_LOOKUP: begin
                for (i = 0; i < int'(rules_held); i++) begin
                    if (!found && (ip & mask_tbl[i]) == net_tbl[i]) begin
                        found = 1'b1;
                        a.hit = 1'b1;
                        a.tag = tag_tbl[i];
                        a.idx = i[3:0];
                    end
                end
                if (found) hits++;
            end
            CMD_INSERT: begin
                if (rules_held >= DEPTH) begin
                    a.status = ST_FULL;
                    fulls++;
                end else if (pos > rules_held) begin
                    a.status = ST_RANGE;
                    ranges++;
                end else begin
                    for (i = int'(rules_held); i > int'(pos); i--) begin
                        net_tbl[i]  = net_tbl[i-1];
                        mask_tbl[i] = mask_tbl[i-1];
                        tag_tbl[i]  = tag_tbl[i-1];
                    end
                    net_tbl[pos]  = net;
                    mask_tbl[pos] = msk;
                    tag_tbl[pos]  = dst;
                    rules_held++;
                end
            end
            CMD_DELETE: begin
                if (pos >= rules_held) begin
                    a.status = ST_RANGE;
                    ranges++;
                end else begin
                    for (i = int'(pos); i + 1 < int'(rules_held); i++) begin
                        net_tbl[i]  = net_tbl[i+1];
                        mask_tbl[i] = mask_tbl[i+1];
                        tag_tbl[i]  = tag_tbl[i+1];
                    end
                    rules_held--;
                end
            end
            default: rules_held = 0;
        endcase
        a.count = rules_held[4:0];
        return a;
    endfunction

    task automatic compare_answer();
        t_answer want;
        results++;
        if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result with no command outstanding (hit %0b tag %h idx %0d)",
                         $time, i_hit, i_dest_tag, i_match_index);
        end else begin
            want = answers_due.pop_front();
            if (i_hit !== want.hit || i_dest_tag !== want.tag || i_match_index !== want.idx ||
                i_entry_count !== want.count || i_status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: mismatch, expected hit %0b tag %h idx %0d count %0d ",
                              "status %0d, got hit %0b tag %h idx %0d count %0d status %0d"},
                             $time, want.hit, want.tag, want.idx, want.count, want.status,
                             i_hit, i_dest_tag, i_match_index, i_entry_count, i_status);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rules_held = 0;
            answers_due.delete();
            mismatches = 0;
            results    = 0;
            hits       = 0;
            fulls      = 0;
            ranges     = 0;
        end else begin
            // a result can never belong to a command taken at the same edge
            if (i_res_valid && !i_res_stall)
                compare_answer();
            if (i_cmd_valid && !i_cmd_stall)
                answers_due.push_back(step_rule_table(t_cmd'(i_cmd), i_ip_addr, i_position,
                                                      i_rule_network, i_rule_mask,
                                                      i_rule_dest));
        end
        o_fail_count     <= mismatches;
        o_waiting        <= answers_due.size();
        o_results_seen   <= results;
        o_lookup_hits    <= hits;
        o_full_refusals  <= fulls;
        o_range_refusals <= ranges;
    end

endmodule

// ----- dv/ordered_ip_subnet_classifier_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_ip_subnet_classifier_core_test - test top for the subnet classifier
// Drives lookup, insert, delete and clear transactions into the block, first
// a hand-picked sequence around the table edges, then a long random mix that
// keeps the table busy and often full. A separate checker predicts and
// compares every result; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module ordered_ip_subnet_classifier_core_test;
    import oisc_pkg::*;

    localparam int RAND_ITEMS   = 1720;
    localparam int HOLD_AT      = 1300;   // transactions sent before the long output hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;     // margin kept after the last result is in

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_stall        = 1'b0;
    logic [1:0]  i_cmd          = CMD_LOOKUP;
    logic [31:0] i_ip_addr      = '0;
    logic [4:0]  i_position     = '0;
    logic [31:0] i_rule_network = '0;
    logic [31:0] i_rule_mask    = '0;
    logic [15:0] i_rule_dest    = '0;

    logic        o_stall;
    logic        o_valid;
    logic        o_hit;
    logic [15:0] o_dest_tag;
    logic [3:0]  o_match_index;
    logic [4:0]  o_entry_count;
    logic [1:0]  o_status;

    int fails;
    int waiting;
    int results_seen;
    int lookup_hits;
    int full_refusals;
    int range_refusals;

    // flow-control knobs, percent of cycles spent idle
    int tx_idle_pct = 24;
    int rx_idle_pct = 75;

    int sent_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Rough view of the table, only used to steer the stimulus: the rule
    // count, and a pool of recently added rules so lookups can aim at them.
    int          rules_now = 0;
    logic [31:0] pool_net[$];
    logic [31:0] pool_mask[$];

    ordered_ip_subnet_classifier_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_ip_addr      (i_ip_addr),
        .i_position     (i_position),
        .i_rule_network (i_rule_network),
        .i_rule_mask    (i_rule_mask),
        .i_rule_dest    (i_rule_dest),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_dest_tag     (o_dest_tag),
        .o_match_index  (o_match_index),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    ordered_ip_subnet_classifier_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_stall      (o_stall),
        .i_cmd            (i_cmd),
        .i_ip_addr        (i_ip_addr),
        .i_position       (i_position),
        .i_rule_network   (i_rule_network),
        .i_rule_mask      (i_rule_mask),
        .i_rule_dest      (i_rule_dest),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_hit            (o_hit),
        .i_dest_tag       (o_dest_tag),
        .i_match_index    (o_match_index),
        .i_entry_count    (o_entry_count),
        .i_status         (o_status),
        .o_fail_count     (fails),
        .o_waiting        (waiting),
        .o_results_seen   (results_seen),
        .o_lookup_hits    (lookup_hits),
        .o_full_refusals  (full_refusals),
        .o_range_refusals (range_refusals)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side stall. Random idling per the current phase, plus one long
    // hold-off while the sender keeps pushing: the block has one command in
    // flight and a pending stage, so it soon has to stall its input too.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Offer one transaction and return at the edge where it is taken. Any idle
    // gap comes first, so valid is only ever lowered between transactions.
    task automatic issue(t_cmd op, logic [31:0] ip, logic [4:0] pos, logic [31:0] net,
                         logic [31:0] msk, logic [15:0] dst);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= op;
        i_ip_addr      <= ip;
        i_position     <= pos;
        i_rule_network <= net;
        i_rule_mask    <= msk;
        i_rule_dest    <= dst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_cnt++;
        // keep the steering view in line with what the block will do
        case (op)
            CMD_INSERT: begin
                if (rules_now < TABLE_DEPTH_DEF && pos <= rules_now) begin
                    rules_now++;
                    pool_net.push_back(net);
                    pool_mask.push_back(msk);
                    if (pool_net.size() > 32) begin
                        void'(pool_net.pop_front());
                        void'(pool_mask.pop_front());
                    end
                end
            end
            CMD_DELETE: if (pos < rules_now) rules_now--;
            CMD_CLEAR:  rules_now = 0;
            default: ;
        endcase
    endtask

    initial begin
        int          n;
        int          k;
        int          pick;
        int unsigned len;
        t_cmd        op;
        logic [31:0] ip;
        logic [31:0] net;
        logic [31:0] msk;
        logic [4:0]  pos;
        logic [15:0] dst;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: empty table, edges of position, full table ----
        issue(CMD_LOOKUP, 32'hFFFF_FFFF, 5'd0, '0, '0, '0);             // miss on empty table
        issue(CMD_DELETE, '0, 5'd0, '0, '0, '0);                        // delete when empty
        issue(CMD_INSERT, '0, 5'd1, '1, '1, 16'hFFFF);                  // position past count
        issue(CMD_INSERT, '0, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        issue(CMD_INSERT, '0, 5'd1, 32'h0, 32'h0, 16'h0001);            // catch-all appended
        issue(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0);               // host rule wins
        issue(CMD_LOOKUP, 32'h0, '0, '0, '0, '0);                       // falls to catch-all
        issue(CMD_INSERT, '0, 5'd31, '1, '1, '1);                       // top position value
        issue(CMD_DELETE, '0, 5'd2, '0, '0, '0);                        // position equal to count
        issue(CMD_INSERT, '0, 5'd1, 32'hC0A8_0000, 32'hFFFF_0000, 16'h0000);
        // fill up from the front so earlier rules slide to the back
        for (k = 0; k < 13; k++)
            issue(CMD_INSERT, '0, 5'd0, {8'd10, k[7:0], 16'h0}, 32'hFFFF_0000,
                  16'h1000 + 16'(k));
        issue(CMD_INSERT, '0, 5'd0, '0, '0, '0);                        // table full
        issue(CMD_INSERT, '0, 5'd31, '0, '0, '0);                       // full beats range
        issue(CMD_LOOKUP, 32'hC0A8_1234, '0, '0, '0, '0);
        issue(CMD_LOOKUP, 32'h0, '0, '0, '0, '0);                       // last slot matches
        issue(CMD_DELETE, '0, 5'd16, '0, '0, '0);
        issue(CMD_DELETE, '0, 5'd15, '0, '0, '0);
        issue(CMD_DELETE, '0, 5'd0, '0, '0, '0);
        issue(CMD_CLEAR, '1, '1, '1, '1, '1);
        issue(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0);

        // ---- random mix ----
        // Inserts outweigh deletes and clears are rare, so the table spends
        // long stretches near or at full; most positions are legal ones.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                tx_idle_pct = 75;
                rx_idle_pct = 24;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            ip   = $urandom;
            pos  = 5'($urandom);
            net  = $urandom;
            msk  = $urandom;
            dst  = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op = CMD_LOOKUP;
                // mostly aim inside a known rule's subnet
                if (pool_net.size() > 0 && $urandom_range(0, 9) < 7) begin
                    k  = $urandom_range(0, pool_net.size() - 1);
                    ip = pool_net[k] | ($urandom & ~pool_mask[k]);
                end
            end else if (pick < 80) begin
                op  = CMD_INSERT;
                len = $urandom_range(0, 32);
                case ($urandom_range(0, 9))
                    6, 7:    msk = $urandom;
                    8:       msk = '0;
                    9:       msk = '1;
                    default: msk = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
                endcase
                // a network with bits outside its mask can never match; keep some
                if ($urandom_range(0, 4) != 0)
                    net = net & msk;
                if ($urandom_range(0, 99) < 85)
                    pos = 5'($urandom_range(0, rules_now));
            end else if (pick < 99) begin
                op = CMD_DELETE;
                if (rules_now > 0 && $urandom_range(0, 99) < 85)
                    pos = 5'($urandom_range(0, rules_now - 1));
            end else begin
                op = CMD_CLEAR;
            end
            issue(op, ip, pos, net, msk, dst);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions through three flow-control phases and one long hold-off",
                 sent_cnt);
        $display("Results checked %0d: lookup hits %0d, full refusals %0d, range refusals %0d",
                 results_seen, lookup_hits, full_refusals, range_refusals);
        if (fails == 0 && waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Timed out with %0d results still outstanding", waiting);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
